[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cfts_pkg.sv]
// shared types and constants of the camera flash trigger sequencer
`default_nettype none

package cfts_pkg;

   // sequencer phases, one-hot
   typedef enum logic [9:0] {
      PH_WAIT    = 10'b00_0000_0001,
      PH_STARTUP = 10'b00_0000_0010,
      PH_IDLE    = 10'b00_0000_0100,
      PH_PLANE   = 10'b00_0000_1000,
      PH_LEAD    = 10'b00_0001_0000,
      PH_ALLCAM  = 10'b00_0010_0000,
      PH_GAP     = 10'b00_0100_0000,
      PH_SPEED   = 10'b00_1000_0000,
      PH_TAIL    = 10'b01_0000_0000,
      PH_REARM   = 10'b10_0000_0000
   } phase_type;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_LASER_SELECT = 2'd0,
      CSR_PLANE_DELAY  = 2'd1,
      CSR_HALF_PERIOD  = 2'd2,
      CSR_REARM_DELAY  = 2'd3
   } csr_index_type;

   localparam int CsrIndexBits = 2;
   localparam int CfgDataBits  = 16;

   // bit positions inside the pin level vector
   localparam int PinBits   = 6;
   localparam int PinL1     = 0;
   localparam int PinL2     = 1;
   localparam int PinFlash  = 2;
   localparam int PinClear  = 3;
   localparam int PinAllCam = 4;
   localparam int PinSpeed  = 5;

   // reset values of the configuration registers
   localparam logic [CfgDataBits-1:0] HalfPeriodReset = 16'd4;
   localparam logic [CfgDataBits-1:0] RearmDelayReset = 16'd84;

   typedef struct packed {
      logic                   laser_select;
      logic [CfgDataBits-1:0] plane_delay_ms;
      logic [CfgDataBits-1:0] half_period_ms;
      logic [CfgDataBits-1:0] rearm_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic laser_one;
      logic laser_two;
      logic flash_level;
      logic sensor_clear;
      logic all_camera;
      logic speed_camera;
      logic sequence_active;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/cfts_csr.sv]
// configuration registers of the camera flash trigger sequencer
`default_nettype none

module cfts_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 wr_en,
   input  wire logic [cfts_pkg::CsrIndexBits-1:0]    wr_index,
   input  wire logic [cfts_pkg::CfgDataBits-1:0]     wr_data,
   output cfts_pkg::cfg_type                         cfg
);

   cfts_pkg::cfg_type cfg_ff;
   cfts_pkg::cfg_type cfg_in;

   // decode one register write per transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (cfts_pkg::csr_index_type'(wr_index))
            cfts_pkg::CSR_LASER_SELECT: cfg_in.laser_select   = wr_data[0];
            cfts_pkg::CSR_PLANE_DELAY:  cfg_in.plane_delay_ms = wr_data;
            cfts_pkg::CSR_HALF_PERIOD:  cfg_in.half_period_ms = wr_data;
            cfts_pkg::CSR_REARM_DELAY:  cfg_in.rearm_delay_ms = wr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.laser_select   <= 1'b0;
         cfg_ff.plane_delay_ms <= '0;
         cfg_ff.half_period_ms <= cfts_pkg::HalfPeriodReset;
         cfg_ff.rearm_delay_ms <= cfts_pkg::RearmDelayReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/cfts_seq.sv]
// phase sequencer: phase, tick counter and pin levels, one tick per step
`default_nettype none

module cfts_seq #(
   parameter int TICK_BITS           = 16,
   parameter int STARTUP_CLEAR_TICKS = 40
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step_en,
   input  wire logic        arm_level,
   input  wire logic        sensor_level,
   input  wire cfts_pkg::cfg_type cfg,
   output cfts_pkg::rsp_type rsp
);

   // plane finish, run of equal-length phases, rearm finish; twice, plus the tick action
   localparam int WalkSteps = 7;

   localparam logic [32:0] TickMax      = (33'd1 << TICK_BITS) - 33'd1;
   localparam logic [32:0] StartupWide  = 33'(STARTUP_CLEAR_TICKS);
   localparam logic [TICK_BITS-1:0] StartupLen =
      (StartupWide > TickMax) ? TickMax[TICK_BITS-1:0] : StartupWide[TICK_BITS-1:0];

   typedef struct packed {
      logic                              zp;
      logic                              zh;
      logic                              zr;
      logic                              sel;
      logic                              arm;
      logic                              sensor;
   } ctx_type;

   typedef struct packed {
      cfts_pkg::phase_type               phase;
      logic                              zero;
      logic                              acted;
      logic                              moved;
      logic [cfts_pkg::PinBits-1:0]      pins;
   } walk_type;

   cfts_pkg::phase_type               phase_ff;
   cfts_pkg::phase_type               phase_in;
   logic [TICK_BITS-1:0]              ticks_ff;
   logic [TICK_BITS-1:0]              ticks_in;
   logic [cfts_pkg::PinBits-1:0]      pins_ff;
   logic [cfts_pkg::PinBits-1:0]      pins_in;

   logic [TICK_BITS-1:0]              plane_len;
   logic [TICK_BITS-1:0]              half_len;
   logic [TICK_BITS-1:0]              rearm_len;
   logic [TICK_BITS-1:0]              ticks_base;
   logic                              active;
   ctx_type                           ctx;
   walk_type                          walk [0:WalkSteps];

   // clamp a configured length to the counter range
   function automatic logic [TICK_BITS-1:0] sat_len(input logic [cfts_pkg::CfgDataBits-1:0] v);
      logic [32:0] wide;
      wide = {17'd0, v};
      return (wide > TickMax) ? TickMax[TICK_BITS-1:0] : wide[TICK_BITS-1:0];
   endfunction

   function automatic logic is_timed(input cfts_pkg::phase_type p);
      return (p != cfts_pkg::PH_WAIT) && (p != cfts_pkg::PH_IDLE);
   endfunction

   // one move: finish a spent phase, or apply the tick's own action once
   function automatic walk_type walk_step(input walk_type w, input ctx_type c);
      walk_type                     n;
      logic [cfts_pkg::PinBits-1:0] sel_mask;
      n        = w;
      sel_mask = c.sel ? (cfts_pkg::PinBits'(1) << cfts_pkg::PinL2)
                       : (cfts_pkg::PinBits'(1) << cfts_pkg::PinL1);
      if (is_timed(w.phase) && w.zero) begin
         n.moved = 1'b1;
         unique case (w.phase)
            cfts_pkg::PH_STARTUP: begin
               n.pins[cfts_pkg::PinClear] = 1'b0;
               n.phase = cfts_pkg::PH_IDLE;
               n.zero  = 1'b0;
            end
            cfts_pkg::PH_PLANE: begin
               n.phase = cfts_pkg::PH_LEAD;
               n.zero  = c.zh;
            end
            cfts_pkg::PH_LEAD, cfts_pkg::PH_ALLCAM, cfts_pkg::PH_GAP,
            cfts_pkg::PH_SPEED, cfts_pkg::PH_TAIL: begin
               if (c.zh) begin
                  // every remaining half-period phase is empty: straight to rearm
                  n.pins[cfts_pkg::PinAllCam] = 1'b0;
                  n.pins[cfts_pkg::PinSpeed]  = 1'b0;
                  n.pins[cfts_pkg::PinClear]  = 1'b1;
                  n.pins[cfts_pkg::PinFlash]  = 1'b0;
                  n.phase = cfts_pkg::PH_REARM;
                  n.zero  = c.zr;
               end else begin
                  n.zero = 1'b0;
                  priority if (w.phase == cfts_pkg::PH_LEAD) begin
                     n.pins[cfts_pkg::PinAllCam] = 1'b1;
                     n.phase = cfts_pkg::PH_ALLCAM;
                  end else if (w.phase == cfts_pkg::PH_ALLCAM) begin
                     n.pins[cfts_pkg::PinAllCam] = 1'b0;
                     n.phase = cfts_pkg::PH_GAP;
                  end else if (w.phase == cfts_pkg::PH_GAP) begin
                     n.pins[cfts_pkg::PinSpeed] = 1'b1;
                     n.phase = cfts_pkg::PH_SPEED;
                  end else if (w.phase == cfts_pkg::PH_SPEED) begin
                     n.pins[cfts_pkg::PinSpeed] = 1'b0;
                     n.phase = cfts_pkg::PH_TAIL;
                  end else begin
                     n.pins[cfts_pkg::PinClear] = 1'b1;
                     n.pins[cfts_pkg::PinFlash] = 1'b0;
                     n.phase = cfts_pkg::PH_REARM;
                     n.zero  = c.zr;
                  end
               end
            end
            cfts_pkg::PH_REARM: begin
               n.pins = w.pins | sel_mask;
               n.pins[cfts_pkg::PinClear] = 1'b0;
               n.phase = cfts_pkg::PH_IDLE;
               n.zero  = 1'b0;
            end
            default: n = w;
         endcase
      end else if (!w.acted) begin
         n.acted = 1'b1;
         if ((w.phase == cfts_pkg::PH_WAIT) && !c.arm) begin
            // arm released: selected laser on, clear pulse starts
            n.pins[cfts_pkg::PinL1]    = 1'b0;
            n.pins[cfts_pkg::PinL2]    = 1'b0;
            n.pins[cfts_pkg::PinFlash] = 1'b0;
            n.pins = n.pins | sel_mask;
            n.pins[cfts_pkg::PinClear] = 1'b1;
            n.phase = cfts_pkg::PH_STARTUP;
            n.zero  = 1'b0;
            n.moved = 1'b1;
         end else if ((w.phase == cfts_pkg::PH_IDLE) && !c.sensor) begin
            // object seen: laser off, flash on, plane delay starts
            n.pins = w.pins & ~sel_mask;
            n.pins[cfts_pkg::PinFlash] = 1'b1;
            n.phase = cfts_pkg::PH_PLANE;
            n.zero  = c.zp;
            n.moved = 1'b1;
         end
      end
      return n;
   endfunction

   assign plane_len = sat_len(cfg.plane_delay_ms);
   assign half_len  = sat_len(cfg.half_period_ms);
   assign rearm_len = sat_len(cfg.rearm_delay_ms);

   assign ctx.zp     = (cfg.plane_delay_ms == '0);
   assign ctx.zh     = (cfg.half_period_ms == '0);
   assign ctx.zr     = (cfg.rearm_delay_ms == '0);
   assign ctx.sel    = cfg.laser_select;
   assign ctx.arm    = arm_level;
   assign ctx.sensor = sensor_level;

   // settle, act, settle again for this tick
   always_comb begin
      walk[0].phase = phase_ff;
      walk[0].zero  = (ticks_ff == '0);
      walk[0].acted = 1'b0;
      walk[0].moved = 1'b0;
      walk[0].pins  = pins_ff;
      for (int i = 0; i < WalkSteps; i++) begin
         walk[i+1] = walk_step(walk[i], ctx);
      end
   end

   // tick count of the phase reached, then this tick is spent
   always_comb begin
      ticks_base = ticks_ff;
      if (walk[WalkSteps].moved) begin
         unique case (walk[WalkSteps].phase)
            cfts_pkg::PH_STARTUP: ticks_base = StartupLen;
            cfts_pkg::PH_PLANE:   ticks_base = plane_len;
            cfts_pkg::PH_LEAD, cfts_pkg::PH_ALLCAM, cfts_pkg::PH_GAP,
            cfts_pkg::PH_SPEED, cfts_pkg::PH_TAIL: ticks_base = half_len;
            cfts_pkg::PH_REARM:   ticks_base = rearm_len;
            default:              ticks_base = '0;
         endcase
      end
      active   = is_timed(walk[WalkSteps].phase);
      ticks_in = active ? (ticks_base - TICK_BITS'(1)) : ticks_base;
      phase_in = walk[WalkSteps].phase;
      pins_in  = walk[WalkSteps].pins;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfts_pkg::PH_WAIT;
         ticks_ff <= '0;
         pins_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         pins_ff  <= pins_in;
      end
   end

   assign rsp.laser_one       = pins_in[cfts_pkg::PinL1];
   assign rsp.laser_two       = pins_in[cfts_pkg::PinL2];
   assign rsp.flash_level     = pins_in[cfts_pkg::PinFlash];
   assign rsp.sensor_clear    = pins_in[cfts_pkg::PinClear];
   assign rsp.all_camera      = pins_in[cfts_pkg::PinAllCam];
   assign rsp.speed_camera    = pins_in[cfts_pkg::PinSpeed];
   assign rsp.sequence_active = active;

endmodule

`default_nettype wire

[rtl/core/camera_flash_trigger_sequencer_top.sv]
// Camera flash trigger sequencer, one millisecond tick per request transfer.
// A tick's pin levels appear on rsp, registered, in the cycle after its req transfer.
// Throughput: one tick per cycle unless stalled; phase and result register load together.
// req_ready drops only while a result waits in the output register for rsp_ready.
// Reset (synchronous): all pins low, waiting for arm, registers at their defaults.
`default_nettype none

module camera_flash_trigger_sequencer_top #(
   parameter int TICK_BITS           = 16,
   parameter int STARTUP_CLEAR_TICKS = 40
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_arm_level,
   input  wire logic                              req_sensor_level,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_laser_one,
   output logic                                   rsp_laser_two,
   output logic                                   rsp_flash_level,
   output logic                                   rsp_sensor_clear,
   output logic                                   rsp_all_camera,
   output logic                                   rsp_speed_camera,
   output logic                                   rsp_sequence_active,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [cfts_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [cfts_pkg::CfgDataBits-1:0]  csr_data
);

   cfts_pkg::cfg_type cfg;
   cfts_pkg::rsp_type rsp_next;
   cfts_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              req_fire;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   cfts_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // request transfer when the result register is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   cfts_seq #(
      .TICK_BITS           (TICK_BITS),
      .STARTUP_CLEAR_TICKS (STARTUP_CLEAR_TICKS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_fire),
      .arm_level    (req_arm_level),
      .sensor_level (req_sensor_level),
      .cfg          (cfg),
      .rsp          (rsp_next)
   );

   // result register
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_laser_one       = rsp_data_ff.laser_one;
   assign rsp_laser_two       = rsp_data_ff.laser_two;
   assign rsp_flash_level     = rsp_data_ff.flash_level;
   assign rsp_sensor_clear    = rsp_data_ff.sensor_clear;
   assign rsp_all_camera      = rsp_data_ff.all_camera;
   assign rsp_speed_camera    = rsp_data_ff.speed_camera;
   assign rsp_sequence_active = rsp_data_ff.sequence_active;

endmodule

`default_nettype wire

[rtl/core/cfts_checker.sv]
// port-level checks of the camera flash trigger sequencer, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module cfts_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_laser_one,
   input wire logic rsp_laser_two,
   input wire logic rsp_flash_level,
   input wire logic rsp_sensor_clear,
   input wire logic rsp_all_camera,
   input wire logic rsp_speed_camera,
   input wire logic rsp_sequence_active
);

   // a stalled result keeps its levels
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_laser_one, rsp_laser_two, rsp_flash_level, rsp_sensor_clear, rsp_all_camera, rsp_speed_camera, rsp_sequence_active}), "stalled result changed")

   // request side only stalls behind a waiting result
   `ASSERT_IMPLIES(a_req_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready, "request stalled without a waiting result")

   // camera pulses never overlap
   `ASSERT_ALWAYS(a_cam_excl, clock, reset, !(rsp_valid && rsp_all_camera && rsp_speed_camera), "both camera pulses high")

   // camera pulses only inside a running sequence with flash on and clear low
   `ASSERT_IMPLIES(a_cam_ctx, clock, reset, rsp_valid && (rsp_all_camera || rsp_speed_camera), rsp_flash_level && rsp_sequence_active && !rsp_sensor_clear, "camera pulse outside flash window")

endmodule

bind camera_flash_trigger_sequencer_top cfts_checker u_cfts_checker (.*);

`default_nettype wire

[bench/camera_flash_trigger_sequencer_top_tb.sv]
// self-checking testbench for the camera flash trigger sequencer top level
module camera_flash_trigger_sequencer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          STARTUP_TICKS = 40;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned HOLD_EVERY    = 600;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned SEGMENTS      = 7;
   localparam int unsigned SEGMENT_TICKS = 160;

   // pin levels in result order: l1 l2 flash clear allcam speed active
   localparam cfts_pkg::rsp_type LV_ALL_LOW    = 7'b000_0000;
   localparam cfts_pkg::rsp_type LV_STARTUP_L1 = 7'b100_1001;
   localparam cfts_pkg::rsp_type LV_IDLE_L1    = 7'b100_0000;
   localparam cfts_pkg::rsp_type LV_LEAD_FLASH = 7'b001_0001;

   // one line of the directed stimulus: a register write or a run of ticks
   typedef struct packed {
      bit                               is_write;
      cfts_pkg::csr_index_type          reg_index;
      logic [cfts_pkg::CfgDataBits-1:0] reg_data;
      logic                             arm;
      logic                             sensor;
      int unsigned                      count;
      bit                               typed;
      cfts_pkg::rsp_type                levels;
   } stim_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_arm_level = 1'b1;
   logic                             req_sensor_level = 1'b1;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_laser_one;
   logic                             rsp_laser_two;
   logic                             rsp_flash_level;
   logic                             rsp_sensor_clear;
   logic                             rsp_all_camera;
   logic                             rsp_speed_camera;
   logic                             rsp_sequence_active;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   cfts_pkg::csr_index_type          csr_index = cfts_pkg::CSR_LASER_SELECT;
   logic [cfts_pkg::CfgDataBits-1:0] csr_data = '0;

   // sequencer shadow state
   cfts_pkg::cfg_type                cfg_shadow = {1'b0, 16'd0, cfts_pkg::HalfPeriodReset,
                                                   cfts_pkg::RearmDelayReset};
   cfts_pkg::phase_type              seq_phase = cfts_pkg::PH_WAIT;
   logic [15:0]                      seq_ticks = '0;
   logic [cfts_pkg::PinBits-1:0]     pin_state = '0;
   cfts_pkg::rsp_type                last_levels = '0;

   cfts_pkg::rsp_type                levels_due[$];
   stim_row_type                     directed_rows[$];
   int unsigned                      fail_count = 0;
   int unsigned                      cycle_count = 0;
   int unsigned                      rsp_transfers = 0;
   int unsigned                      rsp_stall = 0;
   bit                               sender_idles = 1'b1;
   bit                               receiver_idles = 1'b1;

   camera_flash_trigger_sequencer_top #(
      .TICK_BITS(16),
      .STARTUP_CLEAR_TICKS(STARTUP_TICKS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_arm_level(req_arm_level),
      .req_sensor_level(req_sensor_level),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_laser_one(rsp_laser_one),
      .rsp_laser_two(rsp_laser_two),
      .rsp_flash_level(rsp_flash_level),
      .rsp_sensor_clear(rsp_sensor_clear),
      .rsp_all_camera(rsp_all_camera),
      .rsp_speed_camera(rsp_speed_camera),
      .rsp_sequence_active(rsp_sequence_active),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic bit is_timed(cfts_pkg::phase_type p);
      return !(p == cfts_pkg::PH_WAIT || p == cfts_pkg::PH_IDLE);
   endfunction

   // laser_select is read whenever a laser is switched
   function automatic int laser_pin();
      return cfg_shadow.laser_select ? cfts_pkg::PinL2 : cfts_pkg::PinL1;
   endfunction

   function automatic logic [15:0] phase_length(cfts_pkg::phase_type p);
      case (p)
         cfts_pkg::PH_STARTUP: return 16'(STARTUP_TICKS);
         cfts_pkg::PH_PLANE: return cfg_shadow.plane_delay_ms;
         cfts_pkg::PH_LEAD, cfts_pkg::PH_ALLCAM, cfts_pkg::PH_GAP, cfts_pkg::PH_SPEED,
         cfts_pkg::PH_TAIL: return cfg_shadow.half_period_ms;
         cfts_pkg::PH_REARM: return cfg_shadow.rearm_delay_ms;
         default: return '0;
      endcase
   endfunction

   task automatic enter_phase(input cfts_pkg::phase_type p);
      seq_phase = p;
      seq_ticks = phase_length(p);
   endtask

   // run out expired phases, zero-length ones fall through in the same tick
   task automatic settle_phases();
      while (is_timed(seq_phase) && seq_ticks == 0) begin
         case (seq_phase)
            cfts_pkg::PH_STARTUP: begin
               pin_state[cfts_pkg::PinClear] = 1'b0;
               enter_phase(cfts_pkg::PH_IDLE);
            end
            cfts_pkg::PH_PLANE: enter_phase(cfts_pkg::PH_LEAD);
            cfts_pkg::PH_LEAD: begin
               pin_state[cfts_pkg::PinAllCam] = 1'b1;
               enter_phase(cfts_pkg::PH_ALLCAM);
            end
            cfts_pkg::PH_ALLCAM: begin
               pin_state[cfts_pkg::PinAllCam] = 1'b0;
               enter_phase(cfts_pkg::PH_GAP);
            end
            cfts_pkg::PH_GAP: begin
               pin_state[cfts_pkg::PinSpeed] = 1'b1;
               enter_phase(cfts_pkg::PH_SPEED);
            end
            cfts_pkg::PH_SPEED: begin
               pin_state[cfts_pkg::PinSpeed] = 1'b0;
               enter_phase(cfts_pkg::PH_TAIL);
            end
            cfts_pkg::PH_TAIL: begin
               pin_state[cfts_pkg::PinClear] = 1'b1;
               pin_state[cfts_pkg::PinFlash] = 1'b0;
               enter_phase(cfts_pkg::PH_REARM);
            end
            default: begin
               pin_state[laser_pin()] = 1'b1;
               pin_state[cfts_pkg::PinClear] = 1'b0;
               enter_phase(cfts_pkg::PH_IDLE);
            end
         endcase
      end
   endtask

   // pin levels shown during one millisecond tick
   task automatic predict_tick(input logic arm, input logic sensor,
                               output cfts_pkg::rsp_type lv);
      settle_phases();
      if (seq_phase == cfts_pkg::PH_WAIT && !arm) begin
         pin_state[cfts_pkg::PinL1] = 1'b0;
         pin_state[cfts_pkg::PinL2] = 1'b0;
         pin_state[cfts_pkg::PinFlash] = 1'b0;
         pin_state[laser_pin()] = 1'b1;
         pin_state[cfts_pkg::PinClear] = 1'b1;
         enter_phase(cfts_pkg::PH_STARTUP);
      end else if (seq_phase == cfts_pkg::PH_IDLE && !sensor) begin
         pin_state[laser_pin()] = 1'b0;
         pin_state[cfts_pkg::PinFlash] = 1'b1;
         enter_phase(cfts_pkg::PH_PLANE);
      end
      settle_phases();
      lv = {pin_state[cfts_pkg::PinL1], pin_state[cfts_pkg::PinL2],
            pin_state[cfts_pkg::PinFlash], pin_state[cfts_pkg::PinClear],
            pin_state[cfts_pkg::PinAllCam], pin_state[cfts_pkg::PinSpeed],
            is_timed(seq_phase)};
      if (is_timed(seq_phase)) begin
         seq_ticks = seq_ticks - 1'b1;
      end
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic send_tick(input logic arm, input logic sensor, input bit typed,
                            input cfts_pkg::rsp_type given);
      int unsigned       gap;
      cfts_pkg::rsp_type lv;
      gap = sender_idles ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_arm_level <= arm;
      req_sensor_level <= sensor;
      do @(posedge clock); while (!req_ready);
      predict_tick(arm, sensor, lv);
      last_levels = lv;
      levels_due.push_back(typed ? given : lv);
   endtask

   // stop offering ticks and wait for every outstanding result
   task automatic drain_ticks();
      req_valid <= 1'b0;
      do @(posedge clock); while (levels_due.size() != 0);
   endtask

   task automatic write_reg(input cfts_pkg::csr_index_type idx,
                            input logic [cfts_pkg::CfgDataBits-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         cfts_pkg::CSR_LASER_SELECT: cfg_shadow.laser_select = data[0];
         cfts_pkg::CSR_PLANE_DELAY: cfg_shadow.plane_delay_ms = data;
         cfts_pkg::CSR_HALF_PERIOD: cfg_shadow.half_period_ms = data;
         cfts_pkg::CSR_REARM_DELAY: cfg_shadow.rearm_delay_ms = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- directed rows

   function automatic void add_write(input cfts_pkg::csr_index_type idx,
                                     input logic [15:0] data);
      stim_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.reg_index = idx;
      row.reg_data = data;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_ticks(input logic arm, input logic sensor, input int unsigned n);
      stim_row_type row;
      row = '0;
      row.arm = arm;
      row.sensor = sensor;
      row.count = n;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(input logic arm, input logic sensor, input int unsigned n,
                                       input cfts_pkg::rsp_type levels);
      stim_row_type row;
      row = '0;
      row.arm = arm;
      row.sensor = sensor;
      row.count = n;
      row.typed = 1'b1;
      row.levels = levels;
      directed_rows.push_back(row);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_error(input string what, input cfts_pkg::rsp_type want,
                             input cfts_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s, l1 l2 fl cl ac sc act expected %b got %b",
                  $realtime, what, want, got);
      end
   endtask

   // result transfer against the oldest expectation
   always @(posedge clock) begin
      cfts_pkg::rsp_type got;
      cfts_pkg::rsp_type want;
      got = {rsp_laser_one, rsp_laser_two, rsp_flash_level, rsp_sensor_clear,
             rsp_all_camera, rsp_speed_camera, rsp_sequence_active};
      if (!reset && rsp_valid && rsp_ready) begin
         if (levels_due.size() == 0) begin
            flag_error("result transfer with nothing expected", 'x, got);
         end else begin
            want = levels_due.pop_front();
            if (got !== want) begin
               flag_error("pin level mismatch", want, got);
            end
         end
      end
   end

   // receiver: random stall after each transfer while receiver_idles is set, long hold-off now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_transfers++;
            rsp_stall = receiver_idles ? $urandom_range(0, 10) : 0;
            if (rsp_transfers % HOLD_EVERY == 0) begin
               rsp_stall = HOLD_CYCLES;
            end
         end else if (rsp_stall != 0) begin
            rsp_stall--;
         end
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("camera_flash_trigger_sequencer_top test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      stim_row_type row;
      int unsigned  odds;
      int unsigned  waited;

      // waiting for arm: all low, sensor ignored
      add_checked(1'b1, 1'b0, 1, LV_ALL_LOW);
      add_checked(1'b1, 1'b1, 2, LV_ALL_LOW);
      // arm release: laser one and clear pulse for the whole startup
      add_checked(1'b0, 1'b0, 1, LV_STARTUP_L1);
      add_checked(1'b1, 1'b0, STARTUP_TICKS - 1, LV_STARTUP_L1);
      // idle, arm no longer matters
      add_checked(1'b0, 1'b1, 1, LV_IDLE_L1);
      // trigger tick already in the lead, zero plane delay skipped
      add_checked(1'b1, 1'b0, 1, LV_LEAD_FLASH);
      // full default sequence with retrigger on the first idle tick
      add_ticks(1'b0, 1'b0, 108);
      add_ticks(1'b1, 1'b1, 110);
      // all phases zero length, laser switched to the second output
      add_write(cfts_pkg::CSR_LASER_SELECT, 16'd1);
      add_write(cfts_pkg::CSR_PLANE_DELAY, 16'd0);
      add_write(cfts_pkg::CSR_HALF_PERIOD, 16'd0);
      add_write(cfts_pkg::CSR_REARM_DELAY, 16'd0);
      add_ticks(1'b1, 1'b0, 3);
      // short phases, upper data bits of the laser select ignored
      add_write(cfts_pkg::CSR_LASER_SELECT, 16'hFFFE);
      add_write(cfts_pkg::CSR_PLANE_DELAY, 16'd2);
      add_write(cfts_pkg::CSR_HALF_PERIOD, 16'd1);
      add_write(cfts_pkg::CSR_REARM_DELAY, 16'd3);
      add_ticks(1'b0, 1'b0, 1);
      add_ticks(1'b1, 1'b1, 12);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.is_write) begin
            drain_ticks();
            write_reg(row.reg_index, row.reg_data);
         end else begin
            repeat (row.count) send_tick(row.arm, row.sensor, row.typed, row.levels);
         end
      end

      // random segments, each with its own timing and trigger density
      for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
         drain_ticks();
         write_reg(cfts_pkg::CSR_LASER_SELECT, 16'($urandom));
         write_reg(cfts_pkg::CSR_PLANE_DELAY, 16'($urandom_range(0, 12)));
         write_reg(cfts_pkg::CSR_HALF_PERIOD, 16'($urandom_range(0, 6)));
         write_reg(cfts_pkg::CSR_REARM_DELAY, 16'($urandom_range(0, 24)));
         sender_idles = (seg % 3 != 1);
         receiver_idles = (seg % 3 != 2);
         odds = $urandom_range(1, 12);
         repeat (SEGMENT_TICKS) begin
            send_tick(1'($urandom_range(0, 1)), $urandom_range(1, odds) != 1, 1'b0, '0);
         end
      end

      // back to idle before the extreme lengths
      do send_tick(1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);
      while (last_levels.sequence_active);
      drain_ticks();
      write_reg(cfts_pkg::CSR_HALF_PERIOD, 16'hFFFF);
      write_reg(cfts_pkg::CSR_LASER_SELECT, 16'hFFFF);
      repeat (8) send_tick(1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);

      // start of a sequence with the longest plane and rearm delays, no idling
      drain_ticks();
      write_reg(cfts_pkg::CSR_HALF_PERIOD, 16'd2);
      write_reg(cfts_pkg::CSR_PLANE_DELAY, 16'hFFFF);
      write_reg(cfts_pkg::CSR_REARM_DELAY, 16'hFFFF);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      send_tick(1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
      repeat (20) send_tick(1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);

      // wind down
      req_valid <= 1'b0;
      waited = 0;
      while (levels_due.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (levels_due.size() != 0) begin
         flag_error("results still outstanding", levels_due[0], 'x);
      end
      if (fail_count == 0) begin
         $display("camera_flash_trigger_sequencer_top test passed");
      end else begin
         $display("camera_flash_trigger_sequencer_top test failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/cfts_pkg.sv
rtl/core/cfts_csr.sv
rtl/core/cfts_seq.sv
rtl/core/camera_flash_trigger_sequencer_top.sv
rtl/core/cfts_checker.sv
bench/camera_flash_trigger_sequencer_top_tb.sv
